// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the point transform block.
// Needs clk in the scope of each use, and rst_n as well for ASSERT_CLK.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/prst_pkg.sv
// Package for the point rotate/scale/translate block: constants, register
// indexes and the configuration struct. No dependencies.
package prst_pkg;

  localparam int COEF_FRAC_BITS = 20;
  localparam int COORD_W        = 32;
  localparam int COLOR_W        = 24;
  localparam int ZSCALE_W       = 31;
  localparam int CFG_IDX_W      = 3;
  localparam int DATA_W         = 3 * COORD_W + COLOR_W;

  localparam logic [CFG_IDX_W-1:0] REG_COS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZSCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0]  cos_times_scale;
    logic signed [COORD_W-1:0]  sin_times_scale;
    logic        [ZSCALE_W-1:0] z_scale;
    logic signed [COORD_W-1:0]  shift_x;
    logic signed [COORD_W-1:0]  shift_y;
    logic signed [COORD_W-1:0]  shift_z;
  } prst_cfg_t;

endpackage

// File: rtl/point_rotate_scale_translate_top.sv
// Top level of the point rotate/scale/translate block: configuration
// registers and the transform pipeline. Depends on prst_pkg, prst_datapath.
//
//  channel | ports          | tdata (low bit up)              | tuser
//  in      | in_t*          | in_x, in_y, in_z, in_color      | point_ok
//  out     | out_t*         | out_x, out_y, out_z, out_color  | -
//  cfg     | cfg_we/idx/wd  | register write, no read-back    | -
//
// One point per cycle while the output is not stalled; a result is registered in turn by
// the multiply, round and translate stages after its input transfer.
// Synchronous active-low reset clears stage valids and loads register defaults.
// Output stall backs up stage by stage; in_tready drops only when all stages are full.
// Dropped points (point_ok low or out of range) leave no result.
module point_rotate_scale_translate_top #(
  parameter int COEF_FRAC_BITS = prst_pkg::COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [prst_pkg::DATA_W-1:0]    in_tdata,   // in_x, in_y, in_z, in_color
  input  logic                           in_tuser,   // point_ok
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [prst_pkg::DATA_W-1:0]    out_tdata,  // out_x, out_y, out_z, out_color
  input  logic                           cfg_we,
  input  logic [prst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prst_pkg::COORD_W-1:0]   cfg_wdata
);
  import prst_pkg::*;

  localparam logic [COORD_W-1:0]  ONE_COEF  = COORD_W'(1) << COEF_FRAC_BITS;
  localparam logic [ZSCALE_W-1:0] ONE_ZSCAL = ZSCALE_W'(1) << COEF_FRAC_BITS;

  prst_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_times_scale <= ONE_COEF;
      cfg_r.sin_times_scale <= '0;
      cfg_r.z_scale         <= ONE_ZSCAL;
      cfg_r.shift_x         <= '0;
      cfg_r.shift_y         <= '0;
      cfg_r.shift_z         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COS:     cfg_r.cos_times_scale <= cfg_wdata;
        REG_SIN:     cfg_r.sin_times_scale <= cfg_wdata;
        REG_ZSCALE:  cfg_r.z_scale         <= cfg_wdata[ZSCALE_W-1:0];
        REG_SHIFT_X: cfg_r.shift_x         <= cfg_wdata;
        REG_SHIFT_Y: cfg_r.shift_y         <= cfg_wdata;
        REG_SHIFT_Z: cfg_r.shift_z         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  prst_datapath #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/prst_datapath.sv
// Three-stage transform pipeline: multiply, round, translate and range check.
// Depends on prst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module prst_datapath #(
  parameter int COEF_FRAC_BITS = prst_pkg::COEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prst_pkg::prst_cfg_t         cfg,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [prst_pkg::DATA_W-1:0] in_tdata,   // in_x, in_y, in_z, in_color
  input  logic                        in_tuser,   // point_ok
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [prst_pkg::DATA_W-1:0] out_tdata   // out_x, out_y, out_z, out_color
);
  import prst_pkg::*;

  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - COEF_FRAC_BITS;
  localparam int OUT_W  = RND_W + 1;
  localparam logic [SUM_W-1:0] BIAS = SUM_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [COORD_W-1:0] in_x, in_y, in_z;
  logic [COLOR_W-1:0]        in_color;

  assign in_x     = in_tdata[COORD_W-1:0];
  assign in_y     = in_tdata[2*COORD_W-1:COORD_W];
  assign in_z     = in_tdata[3*COORD_W-1:2*COORD_W];
  assign in_color = in_tdata[DATA_W-1:3*COORD_W];

  // stage valids and load enables
  logic s1_v_r, s2_v_r, s3_v_r;
  logic ld1, ld2, ld3;

  assign ld3       = !s3_v_r || out_tready;
  assign ld2       = !s2_v_r || ld3;
  assign ld1       = !s1_v_r || ld2;
  assign in_tready = ld1;

  // stage 1: products
  logic signed [PROD_W-1:0] cx_r, sy_r, sx_r, cy_r, zz_r;
  logic signed [PROD_W-1:0] cx_nxt, sy_nxt, sx_nxt, cy_nxt, zz_nxt;
  logic [COLOR_W-1:0]       col1_r;
  logic signed [COORD_W-1:0] zs_ext;

  assign zs_ext = $signed({1'b0, cfg.z_scale});
  assign cx_nxt = cfg.cos_times_scale * in_x;
  assign sy_nxt = cfg.sin_times_scale * in_y;
  assign sx_nxt = cfg.sin_times_scale * in_x;
  assign cy_nxt = cfg.cos_times_scale * in_y;
  assign zz_nxt = zs_ext * in_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ld1) begin
      s1_v_r <= in_tvalid && in_tuser;
    end
    if (ld1) begin
      cx_r   <= cx_nxt;
      sy_r   <= sy_nxt;
      sx_r   <= sx_nxt;
      cy_r   <= cy_nxt;
      zz_r   <= zz_nxt;
      col1_r <= in_color;
    end
  end

  // stage 2: row sums, round half up
  logic [SUM_W-1:0] sumx, sumy, sumz;
  logic [RND_W-1:0] rx_r, ry_r, rz_r;
  logic [COLOR_W-1:0] col2_r;

  assign sumx = {cx_r[PROD_W-1], cx_r} - {sy_r[PROD_W-1], sy_r} + BIAS;
  assign sumy = {sx_r[PROD_W-1], sx_r} + {cy_r[PROD_W-1], cy_r} + BIAS;
  assign sumz = {zz_r[PROD_W-1], zz_r} + BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ld2) begin
      s2_v_r <= s1_v_r;
    end
    if (ld2) begin
      rx_r   <= sumx[SUM_W-1:COEF_FRAC_BITS];
      ry_r   <= sumy[SUM_W-1:COEF_FRAC_BITS];
      rz_r   <= sumz[SUM_W-1:COEF_FRAC_BITS];
      col2_r <= col1_r;
    end
  end

  // stage 3: translate, range check, output register
  logic [OUT_W-1:0] ox, oy, oz;
  logic             fits;
  logic [DATA_W-1:0] out_r;

  assign ox = {rx_r[RND_W-1], rx_r} +
              {{(OUT_W-COORD_W){cfg.shift_x[COORD_W-1]}}, cfg.shift_x};
  assign oy = {ry_r[RND_W-1], ry_r} +
              {{(OUT_W-COORD_W){cfg.shift_y[COORD_W-1]}}, cfg.shift_y};
  assign oz = {rz_r[RND_W-1], rz_r} +
              {{(OUT_W-COORD_W){cfg.shift_z[COORD_W-1]}}, cfg.shift_z};

  assign fits = ((ox[OUT_W-1:COORD_W-1] == '0) || (ox[OUT_W-1:COORD_W-1] == '1)) &&
                ((oy[OUT_W-1:COORD_W-1] == '0) || (oy[OUT_W-1:COORD_W-1] == '1)) &&
                ((oz[OUT_W-1:COORD_W-1] == '0) || (oz[OUT_W-1:COORD_W-1] == '1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (ld3) begin
      s3_v_r <= s2_v_r && fits;
    end
    if (ld3) begin
      out_r <= {col2_r, oz[COORD_W-1:0], oy[COORD_W-1:0], ox[COORD_W-1:0]};
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = out_r;

  `ASSERT_CLK(a_backpressure_source, !in_tready |-> (out_tvalid && !out_tready), "in_tready low without output stall")
  `ASSERT_CLK(a_s1_holds, (s1_v_r && !ld2) |=> s1_v_r, "stage 1 item lost under stall")
  `ASSERT_CLK(a_out_from_s2, $rose(out_tvalid) |-> $past(s2_v_r), "result without stage 2 item")

endmodule

// File: verif/prst_checker.sv
// Checker for point_rotate_scale_translate_top: tracks register writes, predicts each
// transformed point and compares every output transfer field by field.
// Depends on prst_pkg.
module prst_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [prst_pkg::DATA_W-1:0]    in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [prst_pkg::DATA_W-1:0]    out_tdata,
  input  logic                           cfg_we,
  input  logic [prst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prst_pkg::COORD_W-1:0]   cfg_wdata,
  output int                             mismatch_count,
  output int                             points_waiting
);
  import prst_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COLOR_W-1:0] color;
  } point_t;

  localparam logic signed [65:0] COORD_MIN = -66'sd2147483648;
  localparam logic signed [65:0] COORD_MAX = 66'sd2147483647;

  prst_cfg_t transform_cfg;
  point_t    expected_points[$];
  int        fail_total = 0;
  int        queued = 0;

  assign mismatch_count = fail_total;
  assign points_waiting = queued;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_total++;
  endtask

  // Rotate about z, scale, round half up to the coordinate grid, translate.
  // Returns 0 when the point is dropped.
  function automatic bit transform_point(input prst_cfg_t c, input logic ok,
                                         input logic [DATA_W-1:0] d, output point_t r);
    logic signed [65:0] cs, sn, zs, px, py, pz, half, rx, ry, rz, tx, ty, tz;
    half = 66'sd1 <<< (COEF_FRAC_BITS - 1);
    cs = c.cos_times_scale;
    sn = c.sin_times_scale;
    zs = $signed({1'b0, c.z_scale});
    tx = c.shift_x;
    ty = c.shift_y;
    tz = c.shift_z;
    px = $signed(d[31:0]);
    py = $signed(d[63:32]);
    pz = $signed(d[95:64]);
    rx = ((cs * px - sn * py + half) >>> COEF_FRAC_BITS) + tx;
    ry = ((sn * px + cs * py + half) >>> COEF_FRAC_BITS) + ty;
    rz = ((zs * pz + half) >>> COEF_FRAC_BITS) + tz;
    r.x = rx[31:0];
    r.y = ry[31:0];
    r.z = rz[31:0];
    r.color = d[119:96];
    if (!ok) return 1'b0;
    if (rx < COORD_MIN || rx > COORD_MAX) return 1'b0;
    if (ry < COORD_MIN || ry > COORD_MAX) return 1'b0;
    if (rz < COORD_MIN || rz > COORD_MAX) return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    point_t pt;
    point_t want;
    if (!rst_n) begin
      transform_cfg.cos_times_scale = 32'sd1 <<< COEF_FRAC_BITS;
      transform_cfg.sin_times_scale = '0;
      transform_cfg.z_scale = 31'd1 << COEF_FRAC_BITS;
      transform_cfg.shift_x = '0;
      transform_cfg.shift_y = '0;
      transform_cfg.shift_z = '0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COS:     transform_cfg.cos_times_scale = cfg_wdata;
          REG_SIN:     transform_cfg.sin_times_scale = cfg_wdata;
          REG_ZSCALE:  transform_cfg.z_scale = cfg_wdata[ZSCALE_W-1:0];
          REG_SHIFT_X: transform_cfg.shift_x = cfg_wdata;
          REG_SHIFT_Y: transform_cfg.shift_y = cfg_wdata;
          REG_SHIFT_Z: transform_cfg.shift_z = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, data %h", out_tdata));
        end else begin
          want = expected_points.pop_front();
          if (out_tdata[31:0] !== want.x)
            report_mismatch($sformatf("x got %h exp %h", out_tdata[31:0], want.x));
          if (out_tdata[63:32] !== want.y)
            report_mismatch($sformatf("y got %h exp %h", out_tdata[63:32], want.y));
          if (out_tdata[95:64] !== want.z)
            report_mismatch($sformatf("z got %h exp %h", out_tdata[95:64], want.z));
          if (out_tdata[119:96] !== want.color)
            report_mismatch($sformatf("color got %h exp %h", out_tdata[119:96], want.color));
        end
      end
      if (in_tvalid && in_tready) begin
        if (transform_point(transform_cfg, in_tuser, in_tdata, pt))
          expected_points = {expected_points, pt};
      end
    end
    queued = expected_points.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for point_rotate_scale_translate_top: clock, reset, register
// phases, bursty point stimulus and a stalling receiver; prst_checker judges.
// Depends on prst_pkg, prst_checker and the RTL.
module tb;
  import prst_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_POINTS  = 150;
  localparam int DRAIN_CYCLES  = 16;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKE} rx_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata = '0;   // in_x, in_y, in_z, in_color
  logic                 in_tuser = 1'b0; // point_ok
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;       // out_x, out_y, out_z, out_color
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_wdata = '0;

  int       mismatch_count;
  int       points_waiting;
  int       burst_left = 0;
  int       rx_left = 0;
  rx_mode_e rx_mode = RX_OPEN;

  point_rotate_scale_translate_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  prst_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .points_waiting (points_waiting)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #5000000;
    $display("[point_rotate_scale_translate_top] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(1, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
      default:   out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_point(input logic ok, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [23:0] color);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= ok;
    in_tdata  <= {color, z, y, x};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Stop sending, let every expected result drain, then let dropped points clear.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (points_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] cs, input logic [31:0] sn,
                            input logic [30:0] zs, input logic [31:0] sx,
                            input logic [31:0] sy, input logic [31:0] sz);
    cfg_we <= 1'b1;
    cfg_index <= REG_COS;     cfg_wdata <= cs;                    @(posedge clk);
    cfg_index <= REG_SIN;     cfg_wdata <= sn;                    @(posedge clk);
    cfg_index <= REG_ZSCALE;  cfg_wdata <= {1'($urandom), zs};    @(posedge clk);
    cfg_index <= REG_SHIFT_X; cfg_wdata <= sx;                    @(posedge clk);
    cfg_index <= REG_SHIFT_Y; cfg_wdata <= sy;                    @(posedge clk);
    cfg_index <= REG_SHIFT_Z; cfg_wdata <= sz;                    @(posedge clk);
    // unmapped indexes must be ignored
    cfg_index <= REG_SPARE_LO; cfg_wdata <= $urandom;             @(posedge clk);
    cfg_index <= REG_SPARE_HI; cfg_wdata <= $urandom;             @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord(input bit tight);
    logic [31:0] v;
    v = $urandom;
    if (tight && $urandom_range(0, 4) != 0) return 32'($urandom_range(0, 510)) - 32'd255;
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'($urandom_range(0, 510)) - 32'd255;
      3, 4:    return {{14{v[17]}}, v[17:0]};
      5, 6:    return {{9{v[22]}}, v[22:0]};
      7, 8:    return v;
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return {{10{v[21]}}, v[21:0]};
      4:          return {{20{v[11]}}, v[11:0]};
      5:          return v;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'h0010_0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [30:0] pick_zscale();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1, 2: return {8'd0, v[22:0]};
      3:       return v[30:0];
      4:       return 31'h7FFF_FFFF;
      default: return ($urandom_range(0, 1) != 0) ? 31'd0 : 31'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_shift();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1, 2: return {{8{v[23]}}, v[23:0]};
      3:       return v;
      4:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'h0000_0000;
    endcase
  endfunction

  initial begin
    bit tight;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: identity transform
    send_point(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 24'h000000);
    send_point(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF);
    send_point(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h000000);
    send_point(1'b0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 24'h123456);
    send_point(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 24'hAAAAAA);
    settle();

    // half-LSB products: rounding ties go up
    write_regs(32'h0008_0000, 32'hFFF8_0000, 31'h0008_0000, 32'h0, 32'h0, 32'h0);
    send_point(1'b1, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 24'h555555);
    send_point(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0F0F0F);
    send_point(1'b1, 32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0003, 24'hF0F0F0);
    send_point(1'b1, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 24'h808080);
    settle();

    // largest coefficients and shifts: most points leave the range
    write_regs(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(1'b1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 24'h010203);
    send_point(1'b1, 32'hFFFF_F000, 32'hFFFF_F000, 32'hFFFF_FF00, 24'h040506);
    send_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h070809);
    send_point(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0A0B0C);
    send_point(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0D0E0F);
    settle();

    // zero scale: every point lands on the translation
    write_regs(32'h0, 32'h0, 31'h0, pick_shift(), pick_shift(), pick_shift());
    send_point(1'b1, $urandom, $urandom, $urandom, 24'($urandom));
    send_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'hC3C3C3);
    send_point(1'b0, $urandom, $urandom, $urandom, 24'($urandom));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      tight = (ph < 2);
      if (ph == 0)
        write_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      else if (ph == 1)
        write_regs(32'h8000_0000, 32'h8000_0000, 31'h0,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      else
        write_regs(pick_coef(), pick_coef(), pick_zscale(),
                   pick_shift(), pick_shift(), pick_shift());
      for (int n = 0; n < PHASE_POINTS; n++)
        send_point(($urandom_range(0, 9) != 0), pick_coord(tight), pick_coord(tight),
                   pick_coord(tight), 24'($urandom));
    end
    settle();

    if (mismatch_count == 0 && points_waiting == 0)
      $display("[point_rotate_scale_translate_top] OK");
    else
      $display("[point_rotate_scale_translate_top] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/prst_pkg.sv
rtl/prst_datapath.sv
rtl/point_rotate_scale_translate_top.sv
verif/prst_checker.sv
verif/tb.sv
